### rtl/anm_pkg.sv
package anm_pkg;

	localparam int ANM_MAX_DIM   = 4096;
	localparam int ANM_FRAC_BITS = 16;

	localparam int COEF_W    = 32;
	localparam int SIZE_W    = 13;
	localparam int POS_W     = 12;
	localparam int TERM_W    = 16;
	localparam int CMP_W     = 18;
	localparam int PROD_W    = COEF_W + POS_W + 1;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_XX     = 4'd0,
		REG_INV_XY     = 4'd1,
		REG_INV_X0     = 4'd2,
		REG_INV_YX     = 4'd3,
		REG_INV_YY     = 4'd4,
		REG_INV_Y0     = 4'd5,
		REG_SRC_WIDTH  = 4'd6,
		REG_SRC_HEIGHT = 4'd7
	} reg_idx_t;

endpackage

### rtl/affine_nearest_source_mapper_top.sv
// An accepted request passes in order through multiply, round and bound check to its result.
// Throughput: one request per cycle while the output is not stalled; the three register stages each hold one request.
// Stalls hold each stage in place; bubbles close up ahead of a stalled output.
// Reset: asynchronous, active low; clears all stage valids and loads the
// configuration registers with their default map (identity, 4096 x 4096 source).
module affine_nearest_source_mapper_top #(
	parameter int MAX_DIM   = anm_pkg::ANM_MAX_DIM,
	parameter int FRAC_BITS = anm_pkg::ANM_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [anm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [anm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [anm_pkg::POS_W-1:0]       dest_x,
	input  logic [anm_pkg::POS_W-1:0]       dest_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            inside_res,
	output logic [anm_pkg::POS_W-1:0]       src_x,
	output logic [anm_pkg::POS_W-1:0]       src_y
);
	import anm_pkg::*;

	localparam int TW = FRAC_BITS + TERM_W;

	logic signed [COEF_W-1:0] inv_xx_q, inv_xy_q, inv_x0_q, inv_yx_q, inv_yy_q, inv_y0_q;
	logic [SIZE_W-1:0]        src_width_q, src_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_xx_q     <= 32'sh0001_0000;
			inv_xy_q     <= '0;
			inv_x0_q     <= '0;
			inv_yx_q     <= '0;
			inv_yy_q     <= 32'sh0001_0000;
			inv_y0_q     <= '0;
			src_width_q  <= 13'd4096;
			src_height_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_XX:     inv_xx_q     <= cfg_data;
				REG_INV_XY:     inv_xy_q     <= cfg_data;
				REG_INV_X0:     inv_x0_q     <= cfg_data;
				REG_INV_YX:     inv_yx_q     <= cfg_data;
				REG_INV_YY:     inv_yy_q     <= cfg_data;
				REG_INV_Y0:     inv_y0_q     <= cfg_data;
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SIZE_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	// stage 1: products
	logic signed [PROD_W-1:0] p_xx, p_xy, p_yx, p_yy;
	logic signed [POS_W:0]    dx_sg, dy_sg;
	logic [TW-1:0]            prod_xx_s1, prod_xy_s1, prod_yx_s1, prod_yy_s1;

	assign dx_sg = $signed({1'b0, dest_x});
	assign dy_sg = $signed({1'b0, dest_y});

	always_comb begin
		p_xx = PROD_W'(inv_xx_q) * PROD_W'(dx_sg);
		p_xy = PROD_W'(inv_xy_q) * PROD_W'(dy_sg);
		p_yx = PROD_W'(inv_yx_q) * PROD_W'(dx_sg);
		p_yy = PROD_W'(inv_yy_q) * PROD_W'(dy_sg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			prod_xx_s1 <= p_xx[TW-1:0];
			prod_xy_s1 <= p_xy[TW-1:0];
			prod_yx_s1 <= p_yx[TW-1:0];
			prod_yy_s1 <= p_yy[TW-1:0];
		end
	end

	// stage 2: add offset and half, floor, wrap to 16 bits
	logic signed [PROD_W-1:0] off_x_w, off_y_w;
	logic [TW-1:0]            half, sum_xc, sum_xr, sum_yc, sum_yr;
	logic signed [TERM_W-1:0] tx_col_s2, tx_row_s2, ty_col_s2, ty_row_s2;

	always_comb begin
		off_x_w = PROD_W'(inv_x0_q);
		off_y_w = PROD_W'(inv_y0_q);
		half    = TW'(1) << (FRAC_BITS - 1);
		sum_xc  = prod_xx_s1 + off_x_w[TW-1:0] + half;
		sum_xr  = prod_xy_s1 + half;
		sum_yc  = prod_yx_s1 + off_y_w[TW-1:0] + half;
		sum_yr  = prod_yy_s1 + half;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			tx_col_s2 <= sum_xc[TW-1:FRAC_BITS];
			tx_row_s2 <= sum_xr[TW-1:FRAC_BITS];
			ty_col_s2 <= sum_yc[TW-1:FRAC_BITS];
			ty_row_s2 <= sum_yr[TW-1:FRAC_BITS];
		end
	end

	// stage 3: join terms, bound check
	logic signed [CMP_W-1:0] sx_sum, sy_sum;
	logic [CMP_W-1:0]        lim_x, lim_y, max_dim_c;
	logic                    in_x, in_y, in_bounds;
	logic                    inside_s3;
	logic [POS_W-1:0]        sx_s3, sy_s3;

	always_comb begin
		max_dim_c = CMP_W'(MAX_DIM);
		sx_sum = CMP_W'(tx_col_s2) + CMP_W'(tx_row_s2);
		sy_sum = CMP_W'(ty_col_s2) + CMP_W'(ty_row_s2);
		lim_x  = (CMP_W'(src_width_q) > max_dim_c) ? max_dim_c : CMP_W'(src_width_q);
		lim_y  = (CMP_W'(src_height_q) > max_dim_c) ? max_dim_c : CMP_W'(src_height_q);
		in_x   = !sx_sum[CMP_W-1] && ($unsigned(sx_sum) < lim_x);
		in_y   = !sy_sum[CMP_W-1] && ($unsigned(sy_sum) < lim_y);
		in_bounds = in_x && in_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			inside_s3 <= in_bounds;
			sx_s3     <= in_bounds ? sx_sum[POS_W-1:0] : '0;
			sy_s3     <= in_bounds ? sy_sum[POS_W-1:0] : '0;
		end
	end

	assign out_valid  = valid_s3;
	assign inside_res = inside_s3;
	assign src_x      = sx_s3;
	assign src_y      = sy_s3;

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> src_x == '0 && src_y == '0)
		else $error("outside result carries nonzero coordinates");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_stall)
		else $error("input stalled with a free stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1 && $stable(prod_xx_s1) && $stable(prod_yy_s1))
		else $error("stage one changed while blocked");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv3 |=> valid_s2 && $stable(tx_col_s2) && $stable(ty_row_s2))
		else $error("stage two changed while blocked");

endmodule
